/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while reset is released.
`define WPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define WPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/wpm_pkg.sv */
package wpm_pkg;

    // Field widths fixed by the interface.
    localparam int OP_W  = 2;
    localparam int IDX_W = 6;
    localparam int SYM_W = 5;
    localparam int LEN_W = 7;
    localparam int POS_W = 32;

    // Default pattern capacity and the size of the letter alphabet.
    localparam int PATTERN_MAX_DEF = 64;
    localparam int ALPHABET        = 26;

    // Symbol code that matches any text symbol.
    localparam logic [SYM_W-1:0] WILDCARD = SYM_W'(ALPHABET);

    // Operation codes of a request.
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // One request as held in the input register.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] pat_addr;
        logic [SYM_W-1:0] symbol;
    } wpm_req_t;

    // One result as held in the output queue.
    typedef struct packed {
        logic             match;
        logic [POS_W-1:0] start_position;
    } wpm_res_t;

endpackage

/* rtl/core/wpm_match_core.sv */
module wpm_match_core #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [wpm_pkg::LEN_W-1:0]  cfg_wdata,
    input  logic                       req_fire,
    input  wpm_pkg::wpm_req_t          req,
    output logic                       res_push,
    output wpm_pkg::wpm_res_t          res
);

    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [wpm_pkg::LEN_W-1:0] len_reg;
    logic [wpm_pkg::SYM_W-1:0] store_reg  [PATTERN_MAX];
    logic [wpm_pkg::SYM_W-1:0] store_next [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]    bits_reg, bits_next;
    logic [wpm_pkg::POS_W-1:0] pos_reg, pos_next;

    logic [wpm_pkg::SYM_W-1:0] sym_clamp;
    logic [PATTERN_MAX:0]      shift_ext;
    logic [PATTERN_MAX-1:0]    mask;
    logic [PATTERN_MAX-1:0]    advanced;
    logic [31:0]               len_m1;
    logic [IW-1:0]             sel;
    logic                      hit;

    // Shift-and step: extend every partial match by one symbol and drop the
    // positions whose pattern symbol disagrees with the text symbol.
    always_comb begin
        sym_clamp = (req.symbol > wpm_pkg::WILDCARD) ? wpm_pkg::WILDCARD : req.symbol;
        shift_ext = {bits_reg, 1'b1};
        for (int k = 0; k < PATTERN_MAX; k++) begin
            mask[k] = (store_reg[k] == wpm_pkg::WILDCARD) || (store_reg[k] == req.symbol);
        end
        advanced = shift_ext[PATTERN_MAX-1:0] & mask;
    end

    // Effective length minus one, with zero read as one and overlong values capped.
    always_comb begin
        if (len_reg == '0) begin
            len_m1 = '0;
        end else if (32'(len_reg) > 32'(PATTERN_MAX)) begin
            len_m1 = 32'(PATTERN_MAX - 1);
        end else begin
            len_m1 = 32'(len_reg) - 32'd1;
        end
        sel = len_m1[IW-1:0];
        hit = advanced[sel];
    end

    // Result of a text symbol.
    always_comb begin
        res_push           = req_fire && (req.op == wpm_pkg::OP_TEXT);
        res.match          = hit;
        res.start_position = hit ? (pos_reg - len_m1) : '0;
    end

    // Next state of the scan and the pattern store.
    always_comb begin
        bits_next = bits_reg;
        pos_next  = pos_reg;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            store_next[k] = store_reg[k];
            if (req_fire && (req.op == wpm_pkg::OP_WRITE) && (int'(req.pat_addr) == k)) begin
                store_next[k] = sym_clamp;
            end
        end
        if (req_fire) begin
            case (req.op)
                wpm_pkg::OP_TEXT: begin
                    bits_next = advanced;
                    if (pos_reg != '1) begin
                        pos_next = pos_reg + 32'd1;
                    end
                end
                wpm_pkg::OP_RESTART: begin
                    bits_next = '0;
                    pos_next  = '0;
                end
                default: begin
                    bits_next = bits_reg;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= wpm_pkg::LEN_W'(1);
            bits_reg <= '0;
            pos_reg  <= '0;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                store_reg[k] <= wpm_pkg::WILDCARD;
            end
        end else begin
            if (cfg_we) begin
                len_reg <= cfg_wdata;
            end
            bits_reg <= bits_next;
            pos_reg  <= pos_next;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                store_reg[k] <= store_next[k];
            end
        end
    end

endmodule

/* rtl/core/wpm_out_queue.sv */
module wpm_out_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  wpm_pkg::wpm_res_t          push_data,
    output logic                       full,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_match,
    output logic [wpm_pkg::POS_W-1:0]  m_start_position
);

    wpm_pkg::wpm_res_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    // Two-entry result queue; the head entry drives the output ports.
    always_comb begin
        full             = (cnt_reg == 2'd2);
        m_valid          = (cnt_reg != 2'd0);
        m_match          = entry_reg[rd_ptr_reg].match;
        m_start_position = entry_reg[rd_ptr_reg].start_position;
        pop              = m_valid && m_ready;
        wr_ptr_next      = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next      = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next         = cnt_reg + 2'(push) - 2'(pop);
    end

    // Pointer and count registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/wildcard_pattern_matcher_top.sv */
// Channel   | Direction | Ports
// ----------+-----------+---------------------------------------------------
// request   | in        | s_valid, s_ready, s_op, s_pat_addr, s_symbol
// result    | out       | m_valid, m_ready, m_match, m_start_position
// config    | in        | cfg_we, cfg_wdata (pattern length)
//
// One request is taken per cycle while s_ready is high; a text symbol's result passes
// through the input register, then the result queue, before it is offered on m_valid.
// The combinational shift-and update of the partial-match vector sets the rate.
// Reset (aresetn low, synchronous) loads an all-wildcard pattern of length one.
// A stalled result side fills the two-entry queue, then the input register,
// and only then drops s_ready.
module wildcard_pattern_matcher_top #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [wpm_pkg::LEN_W-1:0]  cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [wpm_pkg::OP_W-1:0]   s_op,
    input  logic [wpm_pkg::IDX_W-1:0]  s_pat_addr,
    input  logic [wpm_pkg::SYM_W-1:0]  s_symbol,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_match,
    output logic [wpm_pkg::POS_W-1:0]  m_start_position
);

    wpm_pkg::wpm_req_t req_reg;
    logic              in_vld_reg, in_vld_next;
    logic              queue_full;
    logic              advance;
    logic              s_fire;
    logic              res_push;
    wpm_pkg::wpm_res_t res;

    // Input register handshake; the held request moves on when the queue has room.
    always_comb begin
        advance     = in_vld_reg && !queue_full;
        s_ready     = !in_vld_reg || advance;
        s_fire      = s_valid && s_ready;
        in_vld_next = s_fire || (in_vld_reg && !advance);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg.op       <= s_op;
            req_reg.pat_addr <= s_pat_addr;
            req_reg.symbol   <= s_symbol;
        end
    end

    wpm_match_core #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_fire  (advance),
        .req       (req_reg),
        .res_push  (res_push),
        .res       (res)
    );

    wpm_out_queue u_queue (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .push             (res_push),
        .push_data        (res),
        .full             (queue_full),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match          (m_match),
        .m_start_position (m_start_position)
    );

endmodule

/* rtl/core/wpm_checker.sv */
`include "assert_macros.svh"

module wpm_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_match,
    input logic [wpm_pkg::POS_W-1:0]  m_start_position
);

    logic                      res_stall;
    logic                      res_nomatch;
    logic                      pos_zero;
    logic [wpm_pkg::POS_W:0]   res_word;

    // Terms shared by the properties below.
    assign res_stall   = m_valid && !m_ready;
    assign res_nomatch = m_valid && !m_match;
    assign pos_zero    = (m_start_position == '0);
    assign res_word    = {m_match, m_start_position};

    // A stalled result stays offered.
    `WPM_ASSERT(a_res_hold, aclk, aresetn, res_stall |=> m_valid, "stalled result dropped")

    // A stalled result keeps its payload.
    `WPM_ASSERT(a_stable, aclk, aresetn, res_stall |=> $stable(res_word), "stalled result changed")

    // A result without a match reports start position zero.
    `WPM_ASSERT(a_nomatch, aclk, aresetn, res_nomatch |-> pos_zero, "position without match")

    // Reset empties the result queue and the input register.
    `WPM_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_valid && s_ready, "not empty after reset")

endmodule

bind wildcard_pattern_matcher_top wpm_checker u_wpm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_match          (m_match),
    .m_start_position (m_start_position)
);

/* dv/wildcard_pattern_matcher_top_tb.sv */
`timescale 1ns / 100ps

module wildcard_pattern_matcher_top_tb;

    localparam int OP_W  = wpm_pkg::OP_W;
    localparam int IDX_W = wpm_pkg::IDX_W;
    localparam int SYM_W = wpm_pkg::SYM_W;
    localparam int LEN_W = wpm_pkg::LEN_W;
    localparam int POS_W = wpm_pkg::POS_W;

    localparam int PAT_DEPTH = wpm_pkg::PATTERN_MAX_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [SYM_W-1:0] SYM_A = 5'd0;
    localparam logic [SYM_W-1:0] SYM_B = 5'd1;
    localparam logic [SYM_W-1:0] SYM_C = 5'd2;
    localparam logic [SYM_W-1:0] SYM_Z = 5'd25;
    localparam logic [SYM_W-1:0] SYM_TOP = 5'd31;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_we;
    logic [LEN_W-1:0]  cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic [OP_W-1:0]   s_op;
    logic [IDX_W-1:0]  s_pat_addr;
    logic [SYM_W-1:0]  s_symbol;
    logic              m_valid;
    logic              m_ready;
    logic              m_match;
    logic [POS_W-1:0]  m_start_position;

    // Shadow copy of the matcher state, advanced on every accepted request.
    logic [SYM_W-1:0]     pattern_copy [PAT_DEPTH];
    logic [PAT_DEPTH-1:0] partial_copy;
    logic [POS_W-1:0]     next_position;
    logic [LEN_W-1:0]     length_copy;
    wpm_pkg::wpm_res_t    match_reports [$];

    int  error_count = 0;
    int  requests_sent = 0;
    int  results_checked = 0;
    int  matches_seen = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;

    wildcard_pattern_matcher_top #(
        .PATTERN_MAX(PAT_DEPTH)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_pat_addr      (s_pat_addr),
        .s_symbol        (s_symbol),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_match         (m_match),
        .m_start_position(m_start_position)
    );

    always #5 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending.",
                     cycle_count, match_reports.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Number of idle cycles before the next request or result; no gap in burst stretches.
    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    // Shift-and update of the shadow state for one accepted request.
    function automatic void match_model_step(input logic [OP_W-1:0] op,
                                             input logic [IDX_W-1:0] idx,
                                             input logic [SYM_W-1:0] sym);
        int unsigned       span;
        logic [POS_W-1:0]  here;
        wpm_pkg::wpm_res_t res;
        case (op)
            wpm_pkg::OP_WRITE: begin
                pattern_copy[idx] = (sym > wpm_pkg::WILDCARD) ? wpm_pkg::WILDCARD : sym;
            end
            wpm_pkg::OP_RESTART: begin
                partial_copy  = '0;
                next_position = '0;
            end
            wpm_pkg::OP_TEXT: begin
                if (length_copy == 0) span = 1;
                else if (length_copy > PAT_DEPTH) span = PAT_DEPTH;
                else span = int'(length_copy);
                here = next_position;
                partial_copy = {partial_copy[PAT_DEPTH-2:0], 1'b1};
                for (int k = 0; k < PAT_DEPTH; k++) begin
                    if (pattern_copy[k] != wpm_pkg::WILDCARD && pattern_copy[k] != sym)
                        partial_copy[k] = 1'b0;
                end
                if (next_position != '1)
                    next_position = next_position + POS_W'(1);
                res.match = partial_copy[span-1];
                res.start_position = res.match ? here - POS_W'(span - 1) : '0;
                match_reports.insert(match_reports.size(), res);
            end
            default: begin
                // The spare operation code leaves everything untouched.
            end
        endcase
    endfunction

    // Present one request after a random gap and hold it until it is taken.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [IDX_W-1:0] idx,
                                input logic [SYM_W-1:0] sym);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_pat_addr <= idx;
        s_symbol   <= sym;
        do @(posedge aclk); while (s_ready !== 1'b1);
        match_model_step(op, idx, sym);
        requests_sent++;
    endtask

    // Drop valid, let every pending result drain, then cover the pipeline depth.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (match_reports.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        length_copy = value;
    endtask

    // Pattern symbols: long patterns stay mostly wildcard so full matches still occur.
    function automatic logic [SYM_W-1:0] pattern_symbol(input bit long_form);
        int r;
        r = $urandom_range(0, 99);
        if (long_form) return (r < 75) ? wpm_pkg::WILDCARD : SYM_A;
        if (r < 25) return wpm_pkg::WILDCARD;
        if (r < 35) return SYM_W'($urandom_range(27, 31));
        return SYM_W'($urandom_range(0, 2));
    endfunction

    function automatic logic [SYM_W-1:0] text_symbol(input bit long_form);
        int r;
        r = $urandom_range(0, 99);
        if (r < (long_form ? 92 : 85))
            return long_form ? SYM_A : SYM_W'($urandom_range(0, 2));
        return SYM_W'($urandom_range(0, 31));
    endfunction

    // Result side: random stall, then take one result and compare it.
    initial begin : result_checker
        wpm_pkg::wpm_res_t want;
        int                stall;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (match_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual match %0b start %0d",
                         $time, m_match, m_start_position);
                error_count++;
            end else begin
                want = match_reports.pop_front();
                if (m_match !== want.match) begin
                    $display("%0t: match mismatch, expected %0b actual %0b",
                             $time, want.match, m_match);
                    error_count++;
                end
                if (m_start_position !== want.start_position) begin
                    $display("%0t: start_position mismatch, expected %0d actual %0d",
                             $time, want.start_position, m_start_position);
                    error_count++;
                end
                results_checked++;
                if (want.match) matches_seen++;
            end
        end
    end

    // Reset state: length one and an all-wildcard pattern match every text symbol.
    task automatic test_reset_defaults();
        send_request(wpm_pkg::OP_TEXT, IDX_W'($urandom_range(0, 63)), SYM_A);
        send_request(wpm_pkg::OP_TEXT, IDX_W'($urandom_range(0, 63)), SYM_Z);
        send_request(wpm_pkg::OP_TEXT, IDX_W'($urandom_range(0, 63)), wpm_pkg::WILDCARD);
        send_request(wpm_pkg::OP_TEXT, IDX_W'($urandom_range(0, 63)), SYM_TOP);
    endtask

    // Pattern a?c with an over-range symbol stored as wildcard, spare op,
    // restart, and a pattern change in the middle of a scan.
    task automatic test_pattern_basics();
        write_length(LEN_W'(3));
        send_request(wpm_pkg::OP_WRITE, IDX_W'(0), SYM_A);
        send_request(wpm_pkg::OP_WRITE, IDX_W'(1), SYM_TOP);
        send_request(wpm_pkg::OP_WRITE, IDX_W'(2), SYM_C);
        send_request(wpm_pkg::OP_WRITE, IDX_W'(63), SYM_Z);
        send_request(wpm_pkg::OP_RESTART, IDX_W'(63), SYM_TOP);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_A);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_B);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_C);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_A);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), 5'd27);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_C);
        send_request(OP_UNUSED, IDX_W'(42), SYM_C);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_A);
        send_request(wpm_pkg::OP_WRITE, IDX_W'(1), SYM_B);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_B);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_C);
        send_request(wpm_pkg::OP_RESTART, IDX_W'(0), SYM_A);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_A);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_B);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_C);
    endtask

    // A length of zero behaves as one; anything above the capacity behaves as the capacity.
    task automatic test_length_limits();
        write_length(LEN_W'(0));
        send_request(wpm_pkg::OP_WRITE, IDX_W'(0), SYM_A);
        send_request(wpm_pkg::OP_RESTART, IDX_W'(0), SYM_A);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_A);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_B);
        write_length(LEN_W'(127));
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_A);
        send_request(wpm_pkg::OP_TEXT, IDX_W'(0), SYM_A);
    endtask

    // One scan: set the length, load the pattern, restart, then stream text with noise.
    task automatic run_scan_phase(input logic [LEN_W-1:0] len_value, input int text_count);
        int span;
        int k;
        int r;
        bit long_form;
        logic [SYM_W-1:0] sym;
        write_length(len_value);
        if (len_value == 0) span = 1;
        else if (len_value > PAT_DEPTH) span = PAT_DEPTH;
        else span = int'(len_value);
        long_form = span > 8;
        if (long_form) begin
            // Clean up letters left by earlier scans so long matches stay reachable.
            for (k = 0; k < PAT_DEPTH; k++) begin
                if (pattern_copy[k] != wpm_pkg::WILDCARD && pattern_copy[k] != SYM_A)
                    send_request(wpm_pkg::OP_WRITE, IDX_W'(k), pattern_symbol(1'b1));
            end
            repeat (4) send_request(wpm_pkg::OP_WRITE, IDX_W'($urandom_range(0, 63)),
                                    pattern_symbol(1'b1));
        end else begin
            for (k = 0; k < span; k++)
                send_request(wpm_pkg::OP_WRITE, IDX_W'(k), pattern_symbol(1'b0));
        end
        send_request(wpm_pkg::OP_RESTART, IDX_W'($urandom_range(0, 63)),
                     SYM_W'($urandom_range(0, 31)));
        for (k = 0; k < text_count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_request(OP_UNUSED, IDX_W'($urandom_range(0, 63)),
                             SYM_W'($urandom_range(0, 31)));
            end else if (r < 7 && !long_form) begin
                send_request(wpm_pkg::OP_RESTART, IDX_W'($urandom_range(0, 63)),
                             SYM_W'($urandom_range(0, 31)));
            end else if (r < 13) begin
                sym = long_form ? pattern_symbol(1'b1) : SYM_W'($urandom_range(0, 31));
                send_request(wpm_pkg::OP_WRITE, IDX_W'($urandom_range(0, 63)), sym);
            end else begin
                send_request(wpm_pkg::OP_TEXT, IDX_W'($urandom_range(0, 63)),
                             text_symbol(long_form));
            end
        end
    endtask

    task automatic test_random_short_scans();
        logic [LEN_W-1:0] lengths [8];
        lengths = '{LEN_W'(0), LEN_W'(1), LEN_W'(2), LEN_W'(3), LEN_W'(5), LEN_W'(8),
                    LEN_W'($urandom_range(1, 8)), LEN_W'($urandom_range(2, 4))};
        for (int i = 0; i < 8; i++) begin
            no_idle = (i % 3 == 1);
            run_scan_phase(lengths[i], 30);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_long_scans();
        run_scan_phase(LEN_W'(64), 90);
        no_idle = 1'b1;
        run_scan_phase(LEN_W'($urandom_range(65, 127)), 90);
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_op          = wpm_pkg::OP_WRITE;
        s_pat_addr    = '0;
        s_symbol      = '0;
        m_ready       = 1'b0;
        length_copy   = LEN_W'(1);
        partial_copy  = '0;
        next_position = '0;
        for (int k = 0; k < PAT_DEPTH; k++) pattern_copy[k] = wpm_pkg::WILDCARD;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_pattern_basics();
        test_length_limits();
        test_random_short_scans();
        test_random_long_scans();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests across pattern lengths 0 to 127, with writes, restarts",
                 requests_sent);
        $display("and spare ops mixed in; checked %0d text results, %0d of them matches.",
                 results_checked, matches_seen);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches found.", error_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/wpm_pkg.sv
rtl/core/wpm_match_core.sv
rtl/core/wpm_out_queue.sv
rtl/core/wildcard_pattern_matcher_top.sv
rtl/core/wpm_checker.sv
dv/wildcard_pattern_matcher_top_tb.sv
